### design/ipid_pkg.sv
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared widths, reciprocal constants, register indexes and term types
// for the integer PID controller.
// ----------------------------------------------------------------------------
package ipid_pkg;

	localparam int unsigned ANGLE_W    = 16;
	localparam int unsigned GAIN_W     = 15;
	localparam int unsigned ILIM_W     = 20;
	localparam int unsigned DLIM_W     = 15;
	localparam int unsigned ERR_W      = 17;
	localparam int unsigned SUM_W      = 21;
	localparam int unsigned SUM_MAG_W  = 20;
	localparam int unsigned RATE_W     = 17;
	localparam int unsigned CFG_DATA_W = 20;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned DRIVE_W    = 16;
	localparam int unsigned TOTAL_W    = 32;

	// Gain products after the power-of-two part of each divisor is shifted out:
	// 1000 = 8 * 125, 100000 = 32 * 3125, 10 = 2 * 5.
	localparam int unsigned P_PRE_SHIFT = 3;
	localparam int unsigned I_PRE_SHIFT = 5;
	localparam int unsigned D_PRE_SHIFT = 1;
	localparam int unsigned PM_W = GAIN_W + ERR_W - P_PRE_SHIFT;
	localparam int unsigned IM_W = GAIN_W + SUM_MAG_W - I_PRE_SHIFT;
	localparam int unsigned DM_W = GAIN_W + RATE_W - D_PRE_SHIFT;

	// Exact reciprocals: q = (m * MAGIC) >> SHIFT equals floor(m / odd divisor)
	// for every m of the given width.
	localparam int unsigned P_MAGIC_W = 30;
	localparam int unsigned I_MAGIC_W = 31;
	localparam int unsigned D_MAGIC_W = 32;
	localparam logic [P_MAGIC_W-1:0] P_MAGIC = 30'd549755814;
	localparam logic [I_MAGIC_W-1:0] I_MAGIC = 31'd1407374884;
	localparam logic [D_MAGIC_W-1:0] D_MAGIC = 32'd3435973837;
	localparam int unsigned P_SHIFT = 36;
	localparam int unsigned I_SHIFT = 42;
	localparam int unsigned D_SHIFT = 34;

	localparam int unsigned QP_W = 23;
	localparam int unsigned QI_W = 19;
	localparam int unsigned QD_W = 29;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_DRIVE_LIMIT    = 3'd4,
		REG_TARGET_ANGLE   = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		ACT_COMPUTE = 1'b0,
		ACT_CLEAR   = 1'b1
	} action_t;

	// Sign and truncated quotient magnitude of each term.
	typedef struct packed {
		logic            p_neg;
		logic [QP_W-1:0] p_mag;
		logic            i_neg;
		logic [QI_W-1:0] i_mag;
		logic            d_neg;
		logic [QD_W-1:0] d_mag;
	} terms_t;

endpackage

### design/ipid_state.sv
// ----------------------------------------------------------------------------
// ipid_state
// Error, clamped integral and filtered measurement change; the controller
// state updates on every accepted word.
// ----------------------------------------------------------------------------
module ipid_state (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic                                adv,
	input  logic                                action,
	input  logic signed [ipid_pkg::ANGLE_W-1:0] measured_angle,
	input  logic signed [ipid_pkg::ANGLE_W-1:0] target_angle,
	input  logic        [ipid_pkg::ILIM_W-1:0]  integral_limit,
	output logic signed [ipid_pkg::ERR_W-1:0]   err_s1,
	output logic signed [ipid_pkg::SUM_W-1:0]   error_sum_q,
	output logic signed [ipid_pkg::RATE_W-1:0]  rate_q
);
	import ipid_pkg::*;

	logic signed [ANGLE_W-1:0] last_measure_q;
	logic                      seeded_q;
	logic signed [ERR_W-1:0]   err;
	logic signed [SUM_W:0]     sum_raw;
	logic signed [SUM_W:0]     lim;
	logic signed [SUM_W-1:0]   sum_next;
	logic signed [ERR_W-1:0]   change;
	logic signed [19:0]        filt_raw;
	logic signed [19:0]        filt_adj;
	logic signed [19:0]        filt_q4;
	logic signed [RATE_W-1:0]  rate_next;

	always_comb begin
		err      = ERR_W'(target_angle) - ERR_W'(measured_angle);
		sum_raw  = (SUM_W+1)'(error_sum_q) + (SUM_W+1)'(err);
		lim      = (SUM_W+1)'({1'b0, integral_limit});
		if (sum_raw > lim) begin
			sum_next = SUM_W'(lim);
		end else if (sum_raw < -lim) begin
			sum_next = SUM_W'(-lim);
		end else begin
			sum_next = SUM_W'(sum_raw);
		end
		change   = seeded_q ? (ERR_W'(measured_angle) - ERR_W'(last_measure_q)) : '0;
		// new = (3 * old + change) / 4, truncated toward zero
		filt_raw = 20'(rate_q) * 20'sd3 + 20'(change);
		filt_adj = filt_raw + (filt_raw[19] ? 20'sd3 : 20'sd0);
		filt_q4  = filt_adj >>> 2;
		rate_next = filt_q4[RATE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q    <= '0;
			rate_q         <= '0;
			last_measure_q <= '0;
			seeded_q       <= 1'b0;
		end else if (accept) begin
			if (action == ACT_CLEAR) begin
				error_sum_q <= '0;
				rate_q      <= '0;
				seeded_q    <= 1'b0;
			end else begin
				error_sum_q    <= sum_next;
				rate_q         <= rate_next;
				last_measure_q <= measured_angle;
				seeded_q       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1 <= err;
		end
	end

endmodule

### design/ipid_terms.sv
// ----------------------------------------------------------------------------
// ipid_terms
// Gain products and exact constant division of the P, I and D terms,
// two register stages.
// ----------------------------------------------------------------------------
module ipid_terms (
	input  logic                               clk,
	input  logic                               adv,
	input  logic        [ipid_pkg::GAIN_W-1:0] gain_p,
	input  logic        [ipid_pkg::GAIN_W-1:0] gain_i,
	input  logic        [ipid_pkg::GAIN_W-1:0] gain_d,
	input  logic signed [ipid_pkg::ERR_W-1:0]  err,
	input  logic signed [ipid_pkg::SUM_W-1:0]  error_sum,
	input  logic signed [ipid_pkg::RATE_W-1:0] rate,
	output ipid_pkg::terms_t                   terms_s3
);
	import ipid_pkg::*;

	logic [ERR_W-1:0]      err_mag;
	logic [SUM_MAG_W-1:0]  sum_mag;
	logic [RATE_W-1:0]     rate_mag;
	logic [SUM_W-1:0]      sum_abs;
	logic [GAIN_W+ERR_W-1:0]     p_prod;
	logic [GAIN_W+SUM_MAG_W-1:0] i_prod;
	logic [GAIN_W+RATE_W-1:0]    d_prod;

	logic [PM_W-1:0] pm_s2;
	logic [IM_W-1:0] im_s2;
	logic [DM_W-1:0] dm_s2;
	logic            p_neg_s2;
	logic            i_neg_s2;
	logic            d_neg_s2;

	logic [PM_W+P_MAGIC_W-1:0] p_recip;
	logic [IM_W+I_MAGIC_W-1:0] i_recip;
	logic [DM_W+D_MAGIC_W-1:0] d_recip;

	always_comb begin
		err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
		sum_abs  = error_sum[SUM_W-1] ? SUM_W'(-error_sum) : SUM_W'(error_sum);
		// the clamp keeps the integral within 20 bits of magnitude
		sum_mag  = sum_abs[SUM_MAG_W-1:0];
		rate_mag = rate[RATE_W-1] ? RATE_W'(-rate) : RATE_W'(rate);
		p_prod   = (GAIN_W+ERR_W)'(gain_p) * (GAIN_W+ERR_W)'(err_mag);
		i_prod   = (GAIN_W+SUM_MAG_W)'(gain_i) * (GAIN_W+SUM_MAG_W)'(sum_mag);
		d_prod   = (GAIN_W+RATE_W)'(gain_d) * (GAIN_W+RATE_W)'(rate_mag);
	end

	// multiply, drop the power-of-two part of each divisor
	always_ff @(posedge clk) begin
		if (adv) begin
			pm_s2    <= p_prod[GAIN_W+ERR_W-1:P_PRE_SHIFT];
			im_s2    <= i_prod[GAIN_W+SUM_MAG_W-1:I_PRE_SHIFT];
			dm_s2    <= d_prod[GAIN_W+RATE_W-1:D_PRE_SHIFT];
			p_neg_s2 <= err[ERR_W-1];
			i_neg_s2 <= error_sum[SUM_W-1];
			// the derivative term is subtracted
			d_neg_s2 <= ~rate[RATE_W-1];
		end
	end

	always_comb begin
		p_recip = (PM_W+P_MAGIC_W)'(pm_s2) * (PM_W+P_MAGIC_W)'(P_MAGIC);
		i_recip = (IM_W+I_MAGIC_W)'(im_s2) * (IM_W+I_MAGIC_W)'(I_MAGIC);
		d_recip = (DM_W+D_MAGIC_W)'(dm_s2) * (DM_W+D_MAGIC_W)'(D_MAGIC);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			terms_s3.p_neg <= p_neg_s2;
			terms_s3.p_mag <= p_recip[P_SHIFT +: QP_W];
			terms_s3.i_neg <= i_neg_s2;
			terms_s3.i_mag <= i_recip[I_SHIFT +: QI_W];
			terms_s3.d_neg <= d_neg_s2;
			terms_s3.d_mag <= d_recip[D_SHIFT +: QD_W];
		end
	end

endmodule

### design/ipid_out.sv
// ----------------------------------------------------------------------------
// ipid_out
// Sum of the signed terms, symmetric clamp and output register.
// ----------------------------------------------------------------------------
module ipid_out (
	input  logic                                clk,
	input  logic                                adv,
	input  ipid_pkg::terms_t                    terms,
	input  logic        [ipid_pkg::DLIM_W-1:0]  drive_limit,
	output logic signed [ipid_pkg::DRIVE_W-1:0] drive_q
);
	import ipid_pkg::*;

	logic signed [TOTAL_W-1:0] p_term;
	logic signed [TOTAL_W-1:0] i_term;
	logic signed [TOTAL_W-1:0] d_term;
	logic signed [TOTAL_W-1:0] total;
	logic signed [TOTAL_W-1:0] lim;
	logic signed [DRIVE_W-1:0] drive_next;

	always_comb begin
		p_term = terms.p_neg ? -TOTAL_W'(terms.p_mag) : TOTAL_W'(terms.p_mag);
		i_term = terms.i_neg ? -TOTAL_W'(terms.i_mag) : TOTAL_W'(terms.i_mag);
		d_term = terms.d_neg ? -TOTAL_W'(terms.d_mag) : TOTAL_W'(terms.d_mag);
		total  = p_term + i_term + d_term;
		lim    = TOTAL_W'(drive_limit);
		if (total > lim) begin
			drive_next = DRIVE_W'(lim);
		end else if (total < -lim) begin
			drive_next = DRIVE_W'(-lim);
		end else begin
			drive_next = total[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q <= drive_next;
		end
	end

endmodule

### design/integer_pid_controller_unit.sv
// ----------------------------------------------------------------------------
// integer_pid_controller_unit
// Integer PID controller with the derivative taken on the measurement.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid / sample_stall): one word per sample holds
//   action and measured_angle. A compute word updates the integral and the
//   rate filter and yields one drive word; a clear word wipes the integral,
//   the filter and the seed flag and yields nothing.
//   Drive channel (drive_valid / drive_stall): one drive word per compute.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   write only while the block is idle. Unknown indexes are ignored.
// Pipeline and throughput:
//   An accepted word passes the state update, gain multiply, reciprocal
//   multiply for the constant divides, then the sum, clamp and output
//   register on its way to drive. One word per cycle is taken while the drive
//   side keeps up; the reciprocal multiplier stage sets the cycle time.
// Stall and reset:
//   While drive_valid is held by drive_stall the whole pipeline holds and
//   sample_stall is raised, so no word is lost or repeated. Reset clears the
//   configuration, controller state and valid bits at once; the data stages
//   are left as they are, since their valid bits mask them.
// ----------------------------------------------------------------------------
module integer_pid_controller_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic                                  action,
	input  logic signed [ipid_pkg::ANGLE_W-1:0]   measured_angle,
	output logic                                  drive_valid,
	input  logic                                  drive_stall,
	output logic signed [ipid_pkg::DRIVE_W-1:0]   drive,
	input  logic                                  cfg_we,
	input  logic        [ipid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [ipid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ipid_pkg::*;

	// configuration registers
	logic        [GAIN_W-1:0]  gain_p_q;
	logic        [GAIN_W-1:0]  gain_i_q;
	logic        [GAIN_W-1:0]  gain_d_q;
	logic        [ILIM_W-1:0]  integral_limit_q;
	logic        [DLIM_W-1:0]  drive_limit_q;
	logic signed [ANGLE_W-1:0] target_angle_q;

	// pipeline control
	logic adv;
	logic accept;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic drive_valid_q;

	logic signed [ERR_W-1:0]  err_s1;
	logic signed [SUM_W-1:0]  error_sum_q;
	logic signed [RATE_W-1:0] rate_q;
	terms_t                   terms_s3;

	// advance everything unless a finished word is held by the receiver
	assign adv          = ~(drive_valid_q & drive_stall);
	assign accept       = sample_valid & adv;
	assign sample_stall = ~adv;
	assign drive_valid  = drive_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			integral_limit_q <= '0;
			drive_limit_q    <= '0;
			target_angle_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_P:         gain_p_q         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:         gain_i_q         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:         gain_d_q         <= cfg_data[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[ILIM_W-1:0];
				REG_DRIVE_LIMIT:    drive_limit_q    <= cfg_data[DLIM_W-1:0];
				REG_TARGET_ANGLE:   target_angle_q   <= cfg_data[ANGLE_W-1:0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	// valid bits move with the payload; clear words leave a bubble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			drive_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1      <= sample_valid & (action == ACT_COMPUTE);
			valid_s2      <= valid_s1;
			valid_s3      <= valid_s2;
			drive_valid_q <= valid_s3;
		end
	end

	ipid_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.adv            (adv),
		.action         (action),
		.measured_angle (measured_angle),
		.target_angle   (target_angle_q),
		.integral_limit (integral_limit_q),
		.err_s1         (err_s1),
		.error_sum_q    (error_sum_q),
		.rate_q         (rate_q)
	);

	ipid_terms u_terms (
		.clk       (clk),
		.adv       (adv),
		.gain_p    (gain_p_q),
		.gain_i    (gain_i_q),
		.gain_d    (gain_d_q),
		.err       (err_s1),
		.error_sum (error_sum_q),
		.rate      (rate_q),
		.terms_s3  (terms_s3)
	);

	ipid_out u_out (
		.clk         (clk),
		.adv         (adv),
		.terms       (terms_s3),
		.drive_limit (drive_limit_q),
		.drive_q     (drive)
	);

endmodule

### design/ipid_checker.sv
// ----------------------------------------------------------------------------
// ipid_checker
// Port-level checks of the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module ipid_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                sample_valid,
	input logic                                sample_stall,
	input logic                                action,
	input logic                                drive_valid,
	input logic                                drive_stall,
	input logic signed [ipid_pkg::DRIVE_W-1:0] drive
);
	import ipid_pkg::*;

	// a held drive word stays put
	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |=> drive_valid && $stable(drive))
		else $error("drive word changed while stalled");

	// the sample side only stalls behind a stalled drive word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> drive_valid && drive_stall)
		else $error("sample stall without a held drive word");

	// a compute word reaches the drive port if the drive side does not stall while it passes the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && (action == ACT_COMPUTE)
		##1 !drive_stall ##1 !drive_stall ##1 !drive_stall |=> drive_valid)
		else $error("compute word did not reach the drive port");

	// the clamp bound never exceeds 15 bits, so the most negative code is unreachable
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> drive != 16'sh8000)
		else $error("drive outside the clamp range");

endmodule

bind integer_pid_controller_unit ipid_checker u_ipid_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.action       (action),
	.drive_valid  (drive_valid),
	.drive_stall  (drive_stall),
	.drive        (drive)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer PID controller.
// ----------------------------------------------------------------------------
// A short table of directed words and register writes runs first. Its rows
// cover reset values, angle extremes, clear words, masking of wide register
// data and writes to unused indexes. Random phases follow, each with its own
// gain and limit setting. A local model of the controller predicts every drive
// word, and the monitor compares each accepted drive word with the oldest
// prediction. Both channels idle at random. One phase holds the drive side
// off for a long stretch so that the pipeline fills and stalls the sample
// side. Registers are rewritten only after every drive word has come back.
// ----------------------------------------------------------------------------
module tb_top;
	import ipid_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 9;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;
	localparam int PHASES         = 12;
	localparam int PHASE_WORDS    = 117;
	localparam int SQUEEZE_PHASE  = 3;
	localparam int STEADY_PHASE   = 6;

	// Indexes with no register behind them; writes there are dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 16'sh8000;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sh7FFF;
	localparam logic [GAIN_W-1:0]         GAIN_MAX  = 15'h7FFF;
	localparam logic [ILIM_W-1:0]         ILIM_MAX  = 20'hFFFFF;

	// Scale factors of the three terms and of the rate filter.
	localparam longint P_SCALE = 1000;
	localparam longint I_SCALE = 100000;
	localparam longint D_SCALE = 10;
	localparam longint LP_KEEP = 3;
	localparam longint LP_DIV  = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         sample_valid;
	logic                         sample_stall;
	logic                         action;
	logic signed [ANGLE_W-1:0]    measured_angle;
	logic                         drive_valid;
	logic                         drive_stall;
	logic signed [DRIVE_W-1:0]    drive;
	logic                         cfg_we;
	logic        [CFG_IDX_W-1:0]  cfg_index;
	logic        [CFG_DATA_W-1:0] cfg_data;

	integer_pid_controller_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.action         (action),
		.measured_angle (measured_angle),
		.drive_valid    (drive_valid),
		.drive_stall    (drive_stall),
		.drive          (drive),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------------
	// Controller model: registers and state as the block holds them
	// ------------------------------------------------------------------------
	logic        [GAIN_W-1:0]  kp, ki, kd;
	logic        [ILIM_W-1:0]  ilim;
	logic        [DLIM_W-1:0]  dlim;
	logic signed [ANGLE_W-1:0] setpoint;

	logic signed [SUM_W-1:0]   err_acc;
	logic signed [ANGLE_W-1:0] prev_angle;
	logic signed [RATE_W-1:0]  rate_lp;
	bit                        seeded;

	// Drive words predicted but not yet seen, oldest first.
	logic signed [DRIVE_W-1:0] drive_expected[$];

	int  fault_count = 0;
	int  idle_cycles = 0;
	bit  steady      = 1'b0;   // no idling on either side
	bit  squeeze     = 1'b0;   // ask the drive side for its long hold
	bit  squeezed    = 1'b0;   // long hold done

	logic signed [ANGLE_W-1:0] walk_angle = '0;
	logic signed [DRIVE_W-1:0] seen_want;

	function automatic longint clamp_mag(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Apply one register write to the model, keeping the register's own bits.
	task automatic model_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_GAIN_P:         kp       = data[GAIN_W-1:0];
			REG_GAIN_I:         ki       = data[GAIN_W-1:0];
			REG_GAIN_D:         kd       = data[GAIN_W-1:0];
			REG_INTEGRAL_LIMIT: ilim     = data[ILIM_W-1:0];
			REG_DRIVE_LIMIT:    dlim     = data[DLIM_W-1:0];
			REG_TARGET_ANGLE:   setpoint = data[ANGLE_W-1:0];
			default: ;
		endcase
	endtask

	// Advance the controller by one sample word; a compute word yields a drive.
	task automatic pid_predict(input logic act, input logic signed [ANGLE_W-1:0] ang,
			output bit has_drive, output logic signed [DRIVE_W-1:0] drv);
		longint err, sum, change, lp, pt, it, dt, total;
		has_drive = 1'b0;
		drv = '0;
		if (act == ACT_CLEAR) begin
			// Keep prev_angle; it is reloaded by the next seed anyway.
			err_acc = '0;
			rate_lp = '0;
			seeded  = 1'b0;
		end else begin
			err = longint'(setpoint) - longint'(ang);
			sum = clamp_mag(longint'(err_acc) + err, longint'(ilim));
			err_acc = SUM_W'(sum);
			// First sample after a clear sees no change, but the filter still decays.
			if (!seeded) begin
				prev_angle = ang;
				seeded = 1'b1;
			end
			change = longint'(ang) - longint'(prev_angle);
			prev_angle = ang;
			lp = (longint'(rate_lp) * LP_KEEP + change) / LP_DIV;
			rate_lp = RATE_W'(lp);
			pt = (longint'(kp) * err) / P_SCALE;
			it = (longint'(ki) * longint'(err_acc)) / I_SCALE;
			dt = -((longint'(kd) * longint'(rate_lp)) / D_SCALE);
			total = clamp_mag(pt + it + dt, longint'(dlim));
			drv = DRIVE_W'(total);
			has_drive = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Mostly no gap, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return GAIN_W'($urandom);
		if (r < 70)
			return GAIN_W'($urandom_range(0, 2000));
		if (r < 85)
			return '0;
		return GAIN_MAX;
	endfunction

	// Offer one sample word and hold it until taken, then predict its drive.
	// A typed expectation replaces the prediction for rows read off by hand.
	task automatic send_word(input logic act, input logic signed [ANGLE_W-1:0] ang,
			input bit typed, input logic signed [DRIVE_W-1:0] want);
		bit has_drive;
		logic signed [DRIVE_W-1:0] drv;
		sample_valid   <= 1'b1;
		action         <= act;
		measured_angle <= ang;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		pid_predict(act, ang, has_drive, drv);
		if (has_drive)
			drive_expected.push_back(typed ? want : drv);
	endtask

	// Drop valid for a random gap; back-to-back words keep valid high.
	task automatic idle_gap();
		int n;
		n = (steady || squeeze) ? 0 : pick_gap();
		if (n > 0) begin
			sample_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold the sample side until every drive word is back, then let any
	// trailing clear word leave the pipeline.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		model_write(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random sample word: slow walks dominate so the filter and the integral
	// see realistic runs; jumps, wide values and extremes fill the rest.
	task automatic pick_word(output logic act, output logic signed [ANGLE_W-1:0] ang);
		int r, w;
		r = $urandom_range(0, 99);
		act = ACT_COMPUTE;
		if (r < 3) begin
			act = ACT_CLEAR;
			ang = ANGLE_W'($urandom);
		end else begin
			if (r < 55) begin
				w = int'(walk_angle) + $urandom_range(0, 600) - 300;
				ang = w[ANGLE_W-1:0];
			end else if (r < 78) begin
				w = $urandom_range(0, 36000) - 18000;
				ang = w[ANGLE_W-1:0];
			end else if (r < 93) begin
				ang = ANGLE_W'($urandom);
			end else begin
				case ($urandom_range(0, 3))
					0:       ang = ANGLE_MIN;
					1:       ang = ANGLE_MAX;
					2:       ang = setpoint;
					default: ang = '0;
				endcase
			end
			walk_angle = ang;
		end
	endtask

	// Write all registers for one random phase; some phases pin extremes.
	task automatic configure_phase(input int ph);
		logic [GAIN_W-1:0]  gp, gi, gd;
		logic [DLIM_W-1:0]  dl;
		logic [ILIM_W-1:0]  il;
		logic [ANGLE_W-1:0] tg;
		int r, w;
		gp = pick_gain();
		gi = pick_gain();
		gd = pick_gain();
		r = $urandom_range(0, 2);
		if (r == 0)
			il = ILIM_W'($urandom_range(0, 5000));
		else if (r == 1)
			il = ILIM_W'($urandom_range(0, 1000000));
		else
			il = ILIM_W'($urandom);
		r = $urandom_range(0, 3);
		if (r < 2)
			dl = DLIM_W'($urandom);
		else if (r == 2)
			dl = GAIN_MAX;
		else
			dl = DLIM_W'($urandom_range(0, 1000));
		if ($urandom_range(0, 3) != 0) begin
			w = $urandom_range(0, 36000) - 18000;
			tg = w[ANGLE_W-1:0];
		end else begin
			tg = ANGLE_W'($urandom);
		end
		case (ph)
			0: begin
				gp = GAIN_MAX;
				gi = GAIN_MAX;
				gd = GAIN_MAX;
				il = ILIM_MAX;
				dl = GAIN_MAX;
			end
			1: begin
				il = '0;
				dl = '0;
			end
			5: begin
				gp = GAIN_MAX;
				gi = GAIN_MAX;
				gd = GAIN_MAX;
				tg = ANGLE_MIN;
			end
			8: begin
				il = 20'd1;
				dl = 15'd1;
				tg = ANGLE_MAX;
			end
			default: ;
		endcase
		// Junk in the unused upper data bits must be ignored.
		write_reg(REG_GAIN_P,         {5'($urandom), gp});
		write_reg(REG_GAIN_I,         {5'($urandom), gi});
		write_reg(REG_GAIN_D,         {5'($urandom), gd});
		write_reg(REG_INTEGRAL_LIMIT, il);
		write_reg(REG_DRIVE_LIMIT,    {5'($urandom), dl});
		write_reg(REG_TARGET_ANGLE,   {4'($urandom), tg});
		write_reg(ph[0] ? REG_SPARE_7 : REG_SPARE_6, CFG_DATA_W'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------------
	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic                  act;
		logic [CFG_DATA_W-1:0] value;
		logic                  typed;
		logic [DRIVE_W-1:0]    want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	function automatic dir_row_t word_row(input logic act, input logic [ANGLE_W-1:0] ang,
			input logic typed, input logic [DRIVE_W-1:0] want);
		dir_row_t row;
		row = '0;
		row.act   = act;
		row.value = {4'h0, ang};
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		dir_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.idx    = idx;
		row.value  = value;
		return row;
	endfunction

	// ------------------------------------------------------------------------
	// Sample side: reset, directed table, random phases, end of run
	// ------------------------------------------------------------------------
	initial begin : sample_side
		logic act;
		logic signed [ANGLE_W-1:0] ang;
		int n;

		sample_valid   <= 1'b0;
		action         <= ACT_COMPUTE;
		measured_angle <= '0;
		cfg_we         <= 1'b0;
		cfg_index      <= REG_GAIN_P;
		cfg_data       <= '0;

		kp = '0; ki = '0; kd = '0;
		ilim = '0; dlim = '0; setpoint = '0;
		err_acc = '0; prev_angle = '0; rate_lp = '0; seeded = 1'b0;

		// Zero gains and limits after reset: every drive is zero.
		dir_rows.push_back(word_row(ACT_COMPUTE, 16'h0000, 1'b1, 16'h0000));
		dir_rows.push_back(word_row(ACT_COMPUTE, ANGLE_MIN, 1'b1, 16'h0000));
		dir_rows.push_back(word_row(ACT_COMPUTE, ANGLE_MAX, 1'b1, 16'h0000));
		dir_rows.push_back(word_row(ACT_CLEAR,   16'h0000, 1'b0, 16'h0000));
		// Full gains, wide integral; upper data bits must be masked.
		dir_rows.push_back(reg_row(REG_GAIN_P,         20'hFFFFF));
		dir_rows.push_back(reg_row(REG_GAIN_I,         20'h07FFF));
		dir_rows.push_back(reg_row(REG_GAIN_D,         20'hFFFFF));
		dir_rows.push_back(reg_row(REG_INTEGRAL_LIMIT, ILIM_MAX));
		dir_rows.push_back(reg_row(REG_TARGET_ANGLE,   20'd18000));
		// Drive limit still zero: the clamp forces zero.
		dir_rows.push_back(word_row(ACT_COMPUTE, ANGLE_MIN, 1'b1, 16'h0000));
		dir_rows.push_back(reg_row(REG_DRIVE_LIMIT,    20'h07FFF));
		// Full-scale steps in both directions through the rate filter.
		dir_rows.push_back(word_row(ACT_COMPUTE, ANGLE_MAX, 1'b0, 16'h0000));
		dir_rows.push_back(word_row(ACT_COMPUTE, ANGLE_MIN, 1'b0, 16'h0000));
		dir_rows.push_back(word_row(ACT_COMPUTE, 16'h0000,  1'b0, 16'h0000));
		// Clear, then a reseed: no change on the first sample.
		dir_rows.push_back(word_row(ACT_CLEAR,   ANGLE_MAX, 1'b0, 16'h0000));
		dir_rows.push_back(word_row(ACT_COMPUTE, 16'd18000, 1'b0, 16'h0000));
		// Most negative setpoint against most positive angle: widest error.
		dir_rows.push_back(reg_row(REG_TARGET_ANGLE,   20'hF8000));
		dir_rows.push_back(word_row(ACT_COMPUTE, ANGLE_MAX, 1'b0, 16'h0000));
		dir_rows.push_back(word_row(ACT_COMPUTE, ANGLE_MAX, 1'b0, 16'h0000));
		// Zero integral limit, then writes to unused indexes.
		dir_rows.push_back(reg_row(REG_INTEGRAL_LIMIT, 20'h00000));
		dir_rows.push_back(word_row(ACT_COMPUTE, 16'd100,   1'b0, 16'h0000));
		dir_rows.push_back(reg_row(REG_SPARE_7,        20'hFFFFF));
		dir_rows.push_back(reg_row(REG_SPARE_6,        20'hFFFFF));
		dir_rows.push_back(word_row(ACT_COMPUTE, -16'sd100, 1'b0, 16'h0000));
		dir_rows.push_back(word_row(ACT_CLEAR,   16'h0000,  1'b0, 16'h0000));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_reg) begin
				wait_drained();
				write_reg(dir_rows[k].idx, dir_rows[k].value);
			end else begin
				send_word(dir_rows[k].act, dir_rows[k].value[ANGLE_W-1:0],
					dir_rows[k].typed, dir_rows[k].want);
				idle_gap();
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			configure_phase(ph);
			steady  = (ph == STEADY_PHASE);
			squeeze = (ph == SQUEEZE_PHASE);
			n = 0;
			// In the squeeze phase keep offering until the long hold is over.
			while (n < PHASE_WORDS || (squeeze && !squeezed)) begin
				pick_word(act, ang);
				send_word(act, ang, 1'b0, '0);
				idle_gap();
				n++;
			end
			steady  = 1'b0;
			squeeze = 1'b0;
		end

		wait_drained();
		if (fault_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Drive side: random stalls, clean runs, and one long hold on request
	// ------------------------------------------------------------------------
	initial begin : drive_side
		int run, hold;
		drive_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze && !squeezed) begin
				drive_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				squeezed = 1'b1;
			end else if (steady) begin
				drive_stall <= 1'b0;
				@(posedge clk);
			end else begin
				run = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
				hold = pick_gap();
				drive_stall <= 1'b0;
				repeat (run) @(posedge clk);
				if (hold > 0) begin
					drive_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: match each accepted drive word with the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && drive_valid && !drive_stall) begin
			if (drive_expected.size() == 0) begin
				$error("drive: expected none, got %0d", drive);
				fault_count++;
			end else begin
				seen_want = drive_expected.pop_front();
				if (drive !== seen_want) begin
					$error("drive: expected %0d, got %0d", seen_want, drive);
					fault_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if no word moves on either side for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (drive_valid && !drive_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL");
		$finish;
	end

endmodule

### integer_pid_controller_unit.f
design/ipid_pkg.sv
design/ipid_state.sv
design/ipid_terms.sv
design/ipid_out.sv
design/integer_pid_controller_unit.sv
design/ipid_checker.sv
dv/tb_top.sv
